// File: rtl/idd_pkg.sv
// Shared types and constants of the isotropic diffusion denoiser.
`timescale 1ns / 1ps
`default_nettype none
package idd_pkg;

	localparam int GEO_W      = 9;
	localparam int KAPPA_W    = 15;
	localparam int PASS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PIX_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_KAPPA      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_TOTAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MUL,
		ST_WRITE
	} eng_st_t;

	typedef struct packed {
		logic busy;
		logic pass_end;
	} eng_stat_t;

endpackage
`default_nettype wire

// File: rtl/iso_diffusion_denoise_core.sv
// Top level of the isotropic diffusion denoiser.
`timescale 1ns / 1ps
`default_nettype none
// Pixels are written and read as one item per cycle while no result is stalled, each write
// stored in frame memory A and each read answered from the current frame in the cycle after
// its transfer. The write that completes the frame starts the remaining diffusion passes,
// during which in_ready is low; the pass sequencer shares the single read port of each frame
// memory, so a border pixel reads only its centre tap and an interior pixel its five taps,
// each then followed by wait, multiply and write. No clearing pass is needed after reset.
module iso_diffusion_denoise_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             opcode,
	input  wire logic [idd_pkg::PIX_W-1:0]        pixel_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [idd_pkg::PIX_W-1:0]             pixel_out,
	output logic                                  last,
	input  wire logic                             cfg_we,
	input  wire logic [idd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [idd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import idd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(DEPTH + 1);
	localparam int DW    = PIX_W + FRAC_BITS;

	logic [KAPPA_W-1:0] kappa_q;
	logic [PASS_W-1:0]  pass_total_q, passes_done_q, pd_new;
	logic [GEO_W-1:0]   width_q, height_q, eff_w, eff_h;
	logic [2*GEO_W-1:0] tot_full;
	logic [IW-1:0]      total, wi_q, ri_q, widx, ridx, wi_next, ri_next;
	logic               cur_b_q, rd_sel_q, out_valid_q, last_q;
	logic               acc, wr_acc, rd_acc, start, more;
	logic [PASS_W:0]    pd_inc;

	logic          e_rd_en, e_wr_en;
	logic [AW-1:0] e_rd_addr, e_wr_addr;
	logic [DW-1:0] e_wr_data, src_data;
	eng_stat_t     stat;

	logic          a_we, a_re, b_we, b_re;
	logic [AW-1:0] a_waddr, a_raddr;
	logic [DW-1:0] a_wdata, rdata_a, rdata_b;

	always_comb begin
		priority if (width_q < GEO_W'(3)) eff_w = GEO_W'(3);
		else if (32'(width_q) > MAX_WIDTH) eff_w = GEO_W'(MAX_WIDTH);
		else eff_w = width_q;
		priority if (height_q < GEO_W'(3)) eff_h = GEO_W'(3);
		else if (32'(height_q) > MAX_HEIGHT) eff_h = GEO_W'(MAX_HEIGHT);
		else eff_h = height_q;
	end

	assign tot_full = (2*GEO_W)'(eff_w) * (2*GEO_W)'(eff_h);
	assign total    = IW'(tot_full);

	assign in_ready = !stat.busy && (!out_valid_q || out_ready);
	assign acc      = in_valid && in_ready;
	assign wr_acc   = acc && (opcode == OP_WRITE);
	assign rd_acc   = acc && (opcode == OP_READ);

	assign widx    = (wi_q >= total) ? '0 : wi_q;
	assign wi_next = widx + IW'(1);
	assign pd_new  = (widx == '0) ? '0 : passes_done_q;
	assign start   = wr_acc && (wi_next == total) && (pd_new < pass_total_q);
	assign ridx    = (ri_q >= total) ? '0 : ri_q;
	assign ri_next = ((ridx + IW'(1)) >= total) ? '0 : ridx + IW'(1);
	assign pd_inc  = {1'b0, passes_done_q} + (PASS_W+1)'(1);
	assign more    = pd_inc < {1'b0, pass_total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kappa_q       <= KAPPA_W'(6554);
			pass_total_q  <= PASS_W'(1);
			width_q       <= GEO_W'(256);
			height_q      <= GEO_W'(256);
			wi_q          <= '0;
			ri_q          <= '0;
			passes_done_q <= '0;
			cur_b_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KAPPA:      kappa_q      <= cfg_data[KAPPA_W-1:0];
					REG_PASS_TOTAL: pass_total_q <= cfg_data[PASS_W-1:0];
					REG_WIDTH:      width_q      <= cfg_data[GEO_W-1:0];
					REG_HEIGHT:     height_q     <= cfg_data[GEO_W-1:0];
					default:        ;
				endcase
			end
			if (wr_acc) begin
				wi_q <= wi_next;
				if (widx == '0) begin
					ri_q          <= '0;
					passes_done_q <= '0;
					cur_b_q       <= 1'b0;
				end
			end
			if (rd_acc) begin
				ri_q <= ri_next;
			end
			if (stat.pass_end) begin
				cur_b_q       <= !cur_b_q;
				passes_done_q <= pd_inc[PASS_W-1:0];
			end
			if (rd_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			rd_sel_q <= cur_b_q;
			last_q   <= (ridx == total - IW'(1));
		end
	end

	// Passes read the current frame and write the other one.
	assign a_we    = wr_acc || (e_wr_en && cur_b_q);
	assign a_waddr = wr_acc ? widx[AW-1:0] : e_wr_addr;
	assign a_wdata = wr_acc ? {pixel_in, {FRAC_BITS{1'b0}}} : e_wr_data;
	assign b_we    = e_wr_en && !cur_b_q;
	assign a_re    = (rd_acc || e_rd_en) && !cur_b_q;
	assign b_re    = (rd_acc || e_rd_en) && cur_b_q;
	assign a_raddr = e_rd_en ? e_rd_addr : ridx[AW-1:0];
	assign src_data = cur_b_q ? rdata_b : rdata_a;

	idd_frame_mem #(.AW(AW), .DW(DW)) u_frame_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (rdata_a)
	);

	idd_frame_mem #(.AW(AW), .DW(DW)) u_frame_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (e_wr_addr),
		.wdata (e_wr_data),
		.re    (b_re),
		.raddr (a_raddr),
		.rdata (rdata_b)
	);

	idd_pass_engine #(.IW(IW), .AW(AW), .FRAC_BITS(FRAC_BITS)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.more     (more),
		.kappa    (kappa_q),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.total    (total),
		.src_data (src_data),
		.rd_en    (e_rd_en),
		.rd_addr  (e_rd_addr),
		.wr_en    (e_wr_en),
		.wr_addr  (e_wr_addr),
		.wr_data  (e_wr_data),
		.stat     (stat)
	);

	assign out_valid = out_valid_q;
	assign pixel_out = rd_sel_q ? rdata_b[DW-1:FRAC_BITS] : rdata_a[DW-1:FRAC_BITS];
	assign last      = last_q;

endmodule
`default_nettype wire

// File: rtl/idd_frame_mem.sv
// Frame memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module idd_frame_mem #(
	parameter int AW = 16,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/idd_pass_engine.sv
// Diffusion pass sequencer: reads the stencil taps, scales and writes interior pixels, copies border pixels.
`timescale 1ns / 1ps
`default_nettype none
module idd_pass_engine #(
	parameter int IW        = 17,
	parameter int AW        = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            more,
	input  wire logic [idd_pkg::KAPPA_W-1:0]     kappa,
	input  wire logic [idd_pkg::GEO_W-1:0]       eff_w,
	input  wire logic [idd_pkg::GEO_W-1:0]       eff_h,
	input  wire logic [IW-1:0]                   total,
	input  wire logic [idd_pkg::PIX_W+FRAC_BITS-1:0] src_data,
	output logic                                 rd_en,
	output logic [AW-1:0]                        rd_addr,
	output logic                                 wr_en,
	output logic [AW-1:0]                        wr_addr,
	output logic [idd_pkg::PIX_W+FRAC_BITS-1:0]  wr_data,
	output idd_pkg::eng_stat_t                   stat
);
	import idd_pkg::*;

	localparam int DW = PIX_W + FRAC_BITS;
	localparam int LW = DW + 3;
	localparam int PW = LW + 16;
	localparam logic [DW-1:0] TOP_VAL = {8'hFF, {FRAC_BITS{1'b0}}};

	eng_st_t st_q, st_d;
	logic [GEO_W-1:0] r_q, c_q;
	logic [IW-1:0] pix_q;
	logic [2:0] tap_q, tap_s1;
	logic vld_s1;
	logic [DW-1:0] ctr_q;
	logic [DW+1:0] sum_q;
	logic signed [PW-1:0] prod_q;
	logic border;
	logic last_tap;
	logic last_pix;
	logic [IW-1:0] tap_idx;
	logic signed [LW-1:0] lap;
	logic signed [PW-1:0] prod_rnd, rsh, v;
	logic [DW-1:0] sat;

	assign border = (r_q == '0) || (c_q == '0) ||
		(r_q == eff_h - GEO_W'(1)) || (c_q == eff_w - GEO_W'(1));
	assign last_tap = border || (tap_q == 3'd4);
	assign last_pix = (pix_q == total - IW'(1));

	always_comb begin
		unique case (tap_q)
			3'd1:    tap_idx = pix_q - IW'(eff_w);
			3'd2:    tap_idx = pix_q - IW'(1);
			3'd3:    tap_idx = pix_q + IW'(1);
			3'd4:    tap_idx = pix_q + IW'(eff_w);
			default: tap_idx = pix_q;
		endcase
	end

	assign lap = $signed(LW'(sum_q)) - $signed(LW'({ctr_q, 2'b00}));
	assign prod_rnd = prod_q + PW'(32768);
	assign rsh = prod_rnd >>> 16;
	assign v = $signed(PW'(ctr_q)) + rsh;

	always_comb begin
		priority if (v[PW-1]) begin
			sat = '0;
		end else if (v > $signed(PW'(TOP_VAL))) begin
			sat = TOP_VAL;
		end else begin
			sat = v[DW-1:0];
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (start) st_d = ST_READ;
			ST_READ:  if (last_tap) st_d = ST_WAIT;
			ST_WAIT:  st_d = ST_MUL;
			ST_MUL:   st_d = ST_WRITE;
			ST_WRITE: st_d = (last_pix && !more) ? ST_IDLE : ST_READ;
			default:  st_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		rd_en         = (st_q == ST_READ);
		rd_addr       = tap_idx[AW-1:0];
		wr_en         = (st_q == ST_WRITE);
		wr_addr       = pix_q[AW-1:0];
		wr_data       = border ? ctr_q : sat;
		stat.busy     = (st_q != ST_IDLE);
		stat.pass_end = (st_q == ST_WRITE) && last_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			vld_s1 <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
			pix_q  <= '0;
			tap_q  <= '0;
		end else begin
			st_q   <= st_d;
			vld_s1 <= (st_q == ST_READ);
			if (st_q == ST_IDLE) begin
				r_q   <= '0;
				c_q   <= '0;
				pix_q <= '0;
				tap_q <= '0;
			end else if (st_q == ST_READ) begin
				tap_q <= tap_q + 3'd1;
			end else if (st_q == ST_WRITE) begin
				tap_q <= '0;
				if (last_pix) begin
					r_q   <= '0;
					c_q   <= '0;
					pix_q <= '0;
				end else begin
					pix_q <= pix_q + IW'(1);
					if (c_q == eff_w - GEO_W'(1)) begin
						c_q <= '0;
						r_q <= r_q + GEO_W'(1);
					end else begin
						c_q <= c_q + GEO_W'(1);
					end
				end
			end
		end
	end

	// Tap data arrives in the cycle after its read is issued.
	always_ff @(posedge clk) begin
		tap_s1 <= tap_q;
		if (vld_s1) begin
			if (tap_s1 == 3'd0) begin
				ctr_q <= src_data;
				sum_q <= '0;
			end else begin
				sum_q <= sum_q + (DW+2)'(src_data);
			end
		end
		if (st_q == ST_MUL) begin
			prod_q <= $signed({1'b0, kappa}) * lap;
		end
	end

endmodule
`default_nettype wire

// File: rtl/idd_checker.sv
// Port-level checks of the denoiser and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module idd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       opcode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] pixel_out,
	input wire logic       last
);
	import idd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last))
		else $error("result changed while stalled");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_READ) |=> out_valid)
		else $error("read transfer gave no result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_WRITE) |=> !out_valid)
		else $error("write transfer gave a result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while a result is stalled");

endmodule

bind iso_diffusion_denoise_core idd_checker u_idd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_out (pixel_out),
	.last      (last)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the isotropic diffusion denoiser core.
`timescale 1ns / 1ps

class diffusion_predictor;
	typedef struct {
		logic [7:0] pix;
		logic       last;
	} pixel_result_t;

	int unsigned   frame_a[65536];
	int unsigned   frame_b[65536];
	bit            written_a[65536];
	bit            written_b[65536];
	int unsigned   wr_idx, rd_idx, passes_done;
	bit            cur_b;
	int unsigned   kappa = 6554, pass_total = 1, width = 256, height = 256;
	pixel_result_t expected_pixels[$];
	int            mismatches, checked, frames, passes_run;

	function int unsigned clamp_geo(int unsigned v);
		return (v < 3) ? 3 : ((v > 256) ? 256 : v);
	endfunction

	function int unsigned pixel_count();
		return clamp_geo(width) * clamp_geo(height);
	endfunction

	function void set_reg(logic [idd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			idd_pkg::REG_KAPPA:      kappa = val[14:0];
			idd_pkg::REG_PASS_TOTAL: pass_total = val;
			idd_pkg::REG_WIDTH:      width = val[8:0];
			idd_pkg::REG_HEIGHT:     height = val[8:0];
		endcase
	endfunction

	// A read is allowed only if the entry it lands on holds data.
	function bit read_safe();
		int unsigned ri;
		ri = (rd_idx >= pixel_count()) ? 0 : rd_idx;
		return cur_b ? written_b[ri] : written_a[ri];
	endfunction

	function int unsigned src_at(int unsigned at);
		return cur_b ? frame_b[at] : frame_a[at];
	endfunction

	function void diffuse_once();
		int unsigned w, h, at, res;
		longint u, lap, v;
		w = clamp_geo(width);
		h = clamp_geo(height);
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				at = r * w + c;
				if (r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
					res = src_at(at);
				end else begin
					u = src_at(at);
					lap = longint'(src_at(at - w)) + src_at(at - 1) + src_at(at + 1)
						+ src_at(at + w) - 4 * u;
					// Arithmetic shift gives the floor, so this rounds half up.
					v = u + ((longint'(kappa) * lap + 32768) >>> 16);
					if (v < 0) v = 0;
					if (v > (255 << 8)) v = 255 << 8;
					res = 32'(v);
				end
				if (cur_b) begin
					frame_a[at] = res;
					written_a[at] = 1;
				end else begin
					frame_b[at] = res;
					written_b[at] = 1;
				end
			end
		end
	endfunction

	function void note_input(logic op, logic [7:0] pix);
		int unsigned t, v;
		pixel_result_t e;
		t = pixel_count();
		if (op == idd_pkg::OP_WRITE) begin
			if (wr_idx >= t) wr_idx = 0;
			if (wr_idx == 0) begin
				rd_idx = 0;
				passes_done = 0;
				cur_b = 0;
			end
			frame_a[wr_idx] = pix << 8;
			written_a[wr_idx] = 1;
			wr_idx++;
			if (wr_idx == t) begin
				frames++;
				while (passes_done < pass_total) begin
					diffuse_once();
					cur_b = !cur_b;
					passes_done++;
					passes_run++;
				end
			end
		end else begin
			if (rd_idx >= t) rd_idx = 0;
			v = cur_b ? frame_b[rd_idx] : frame_a[rd_idx];
			e.pix = 8'(v >> 8);
			e.last = (rd_idx == t - 1);
			expected_pixels.push_back(e);
			rd_idx++;
			if (rd_idx >= t) rd_idx = 0;
		end
	endfunction

	function void check_result(logic [7:0] pix, logic last);
		pixel_result_t e;
		checked++;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result pixel=%0d last=%0b", pix, last);
			return;
		end
		e = expected_pixels.pop_front();
		if (pix !== e.pix || last !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result %0d: expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
					checked, e.pix, e.last, pix, last);
		end
	endfunction
endclass

module testbench;
	import idd_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  opcode;
	logic [PIX_W-1:0]      pixel_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [PIX_W-1:0]      pixel_out;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	diffusion_predictor sb = new();
	bit  no_idle;
	bit  hold_req;
	int  stall_left;
	int  idle_cycles;
	int  items_sent;

	iso_diffusion_denoise_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_out(pixel_out), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	// Receiver with random stalls; a hold request parks it for a long stretch.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left--;
		end else if (hold_req) begin
			hold_req = 0;
			out_ready <= 0;
			stall_left = 400;
		end else if (no_idle || $urandom_range(99) < 70) begin
			out_ready <= 1;
		end else begin
			out_ready <= 0;
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(2);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(pixel_out, last);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Called and returns at a falling edge; valid stays high when no gap follows.
	task automatic send(logic op, logic [7:0] pix);
		int g;
		in_valid <= 1;
		opcode <= op;
		pixel_in <= pix;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, pix);
		items_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic read_pixel();
		if (sb.read_safe())
			send(OP_READ, 8'($urandom_range(255)));
		else
			send(OP_WRITE, rand_pixel());
	endtask

	// Drain all results and wait out any diffusion passes before touching registers.
	task automatic settle();
		int run;
		in_valid <= 0;
		while (sb.expected_pixels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		run = 0;
		while (run < 16) begin
			@(negedge clk);
			run = in_ready ? run + 1 : 0;
		end
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_frame();
		int unsigned t;
		t = sb.pixel_count();
		for (int unsigned i = 0; i < t; i++) send(OP_WRITE, rand_pixel());
	endtask

	initial begin
		int unsigned t, n, phase;
		logic [7:0] pattern [9] = '{0, 255, 0, 255, 128, 255, 0, 255, 1};
		in_valid = 0;
		opcode = 0;
		pixel_in = 0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		arst_n = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Geometry below the minimum, zero passes, kappa above the stable limit.
		cfg_write(REG_WIDTH, 0);
		cfg_write(REG_HEIGHT, 2);
		cfg_write(REG_KAPPA, 16'h7fff);
		cfg_write(REG_PASS_TOTAL, 0);
		for (int i = 0; i < 9; i++) send(OP_WRITE, pattern[i]);
		for (int i = 0; i < 10; i++) send(OP_READ, 8'hff);
		settle();
		// A new frame starts; the largest pass count is never reached before it changes.
		cfg_write(REG_PASS_TOTAL, 16'hffff);
		for (int i = 0; i < 3; i++) send(OP_WRITE, pattern[i]);
		send(OP_READ, 8'h00);
		settle();
		// Geometry grows mid-frame, then the frame completes with saturating passes.
		cfg_write(REG_PASS_TOTAL, 2);
		cfg_write(REG_WIDTH, 4);
		for (int i = 0; i < 9; i++) send(OP_WRITE, pattern[8 - i]);
		for (int i = 0; i < 12; i++) send(OP_READ, 8'h00);

		phase = 0;
		while (items_sent < 1750) begin
			settle();
			no_idle = ($urandom_range(4) == 0);
			case ($urandom_range(4))
				0: cfg_write(REG_KAPPA, 0);
				1: cfg_write(REG_KAPPA, 16'h7fff);
				2: cfg_write(REG_KAPPA, 16384);
				3: cfg_write(REG_KAPPA, 6554);
				default: cfg_write(REG_KAPPA, 16'($urandom_range(32767)));
			endcase
			if (phase == 1) begin
				cfg_write(REG_WIDTH, 511);
				cfg_write(REG_HEIGHT, 3);
				cfg_write(REG_PASS_TOTAL, 1);
				write_frame();
				for (int i = 0; i < 40; i++) read_pixel();
			end else if (phase == 2) begin
				// Tall frame, only partly loaded before the geometry changes again.
				cfg_write(REG_WIDTH, 3);
				cfg_write(REG_HEIGHT, 256);
				for (int i = 0; i < 20; i++) send(OP_WRITE, rand_pixel());
				for (int i = 0; i < 10; i++) read_pixel();
			end else if (phase == 4) begin
				cfg_write(REG_WIDTH, 3);
				cfg_write(REG_HEIGHT, 3);
				cfg_write(REG_PASS_TOTAL, 3);
				write_frame();
				hold_req = 1;
				for (int i = 0; i < 40; i++) send(OP_READ, 8'($urandom_range(255)));
			end else begin
				if ($urandom_range(9) == 0) begin
					cfg_write(REG_WIDTH, 16'($urandom_range(5)));
					cfg_write(REG_HEIGHT, 16'($urandom_range(5)));
				end else begin
					cfg_write(REG_WIDTH, 16'($urandom_range(9, 3)));
					cfg_write(REG_HEIGHT, 16'($urandom_range(9, 3)));
				end
				cfg_write(REG_PASS_TOTAL, 16'(
					($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3)));
				if ($urandom_range(9) < 8) begin
					write_frame();
					t = sb.pixel_count();
					n = $urandom_range(t + 3, 1);
					for (int unsigned i = 0; i < n; i++) read_pixel();
				end else begin
					n = $urandom_range(20, 1);
					for (int unsigned i = 0; i < n; i++) begin
						if ($urandom_range(1)) read_pixel();
						else send(OP_WRITE, rand_pixel());
					end
				end
			end
			phase++;
		end

		in_valid <= 0;
		while (sb.expected_pixels.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Covered %0d items over %0d setups: %0d frames loaded, %0d passes run.",
			items_sent, phase + 3, sb.frames, sb.passes_run);
		$display("Checked %0d result pixels, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
